@@ rtl/tach_pkg.sv @@
// ----------------------------------------------------------------------------
// Tachometer speed package
// Shared widths, register indexes, reset values and the divider request and
// response types.
// ----------------------------------------------------------------------------
package tach_pkg;

  localparam int CHANNEL_COUNT = 4;
  localparam int CH_W          = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int SPEED_FIELDS  = 4;

  localparam int WEIGHT_W   = 17;
  localparam int SCALE_W    = 24;
  localparam int STAMP_W    = 32;
  localparam int PERIOD_W   = 40;
  localparam int SPEED_W    = 32;
  localparam int ACC_W      = 58;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_ADDR_W-1:0] REG_WEIGHT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE  = 1'd1;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 17'd58982;
  localparam logic [SCALE_W-1:0]  SCALE_RST  = 24'd2617994;
  localparam logic [15:0]         HALF_WORD  = 16'h8000;
  localparam logic [ACC_W-1:0]    ROUND_HALF = 58'd32768;

  typedef logic [PERIOD_W-1:0] period_t;
  typedef logic [SPEED_W-1:0]  speed_t;
  typedef logic [STAMP_W-1:0]  stamp_t;

  typedef struct packed {
    logic    start;
    period_t dividend;
    period_t divisor;
  } div_req_t;

  typedef struct packed {
    logic    done;
    period_t quot;
  } div_rsp_t;

endpackage

@@ rtl/tach_ifs.sv @@
// ----------------------------------------------------------------------------
// Tachometer speed channel interfaces
// Valid/ready channels for capture and read items, speed results and
// register writes.
// ----------------------------------------------------------------------------
interface tach_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [1:0]  channel;
  logic [15:0] capture_low;
  logic [15:0] high_first;
  logic [15:0] high_second;

  modport source (output valid, mode, channel, capture_low, high_first, high_second,
                  input ready);
  modport sink (input valid, mode, channel, capture_low, high_first, high_second,
                output ready);
endinterface

interface tach_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] speed_zero;
  logic [31:0] speed_one;
  logic [31:0] speed_two;
  logic [31:0] speed_three;

  modport source (output valid, speed_zero, speed_one, speed_two, speed_three,
                  input ready);
  modport sink (input valid, speed_zero, speed_one, speed_two, speed_three,
                output ready);
endinterface

interface tach_cfg_if;
  import tach_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

@@ rtl/tach_div.sv @@
// ----------------------------------------------------------------------------
// Tachometer serial divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tach_div (
  input  logic               clk,
  input  logic               rst_n,
  input  tach_pkg::div_req_t req,
  output tach_pkg::div_rsp_t rsp
);
  import tach_pkg::*;

  localparam int DIV_STEPS = PERIOD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  period_t          rem_r;
  period_t          quo_r;
  period_t          dsr_r;

  logic [PERIOD_W:0] rem_sh;
  logic [PERIOD_W:0] rem_sub;
  logic              ge;

  always_comb begin
    rem_sh  = {rem_r, quo_r[PERIOD_W-1]};
    ge      = (rem_sh >= {1'b0, dsr_r});
    rem_sub = rem_sh - {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
      quo_r <= {quo_r[PERIOD_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

@@ rtl/four_channel_tachometer_speed.sv @@
// ----------------------------------------------------------------------------
// Four-channel tachometer speed
// Timestamps capture events, smooths each channel's period and turns the
// smoothed periods into speeds on request.
// ----------------------------------------------------------------------------
// A capture transaction occupies the block after acceptance for one step that
// forms the period difference and three passes through a shared 17 by 32 bit
// multiplier that build the moving average. A read transaction walks the
// channels in order; a channel with a nonzero smoothed period goes through the
// one-bit-per-cycle serial divider, a channel with a zero period skips it, and
// a final step loads the result register. If an earlier result still waits
// there, the read holds in its last step until the receiver takes that
// result. The block accepts no item while it works on one, but a finished
// result may wait in its output register while capture transactions are taken.
module four_channel_tachometer_speed (
  input logic        clk,
  input logic        rst_n,
  tach_in_if.sink    in_ch,
  tach_out_if.source out_ch,
  tach_cfg_if.sink   cfg_ch
);
  import tach_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIFF = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  localparam logic [1:0] STEP_LAST = 2'd2;

  logic [2:0]          state_r, state_nxt;
  logic [CH_W-1:0]     cur_r, cur_nxt;
  logic [1:0]          step_r, step_nxt;
  logic [WEIGHT_W-1:0] weight_r;
  logic [SCALE_W-1:0]  scale_r;
  stamp_t              stamp_r;
  stamp_t              diff_r;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic                out_valid_r;

  stamp_t  prev_r [CHANNEL_COUNT];
  period_t per_r  [CHANNEL_COUNT];
  speed_t  last_r [CHANNEL_COUNT];
  speed_t  spd_r  [SPEED_FIELDS];
  speed_t  spd_src [SPEED_FIELDS];

  logic                in_acc;
  logic                chan_ok;
  logic                last_cur;
  logic                out_load;
  logic [15:0]         high_sel;
  stamp_t              stamp_in;
  logic [WEIGHT_W-1:0] w_clamp;
  logic [WEIGHT_W-1:0] w_comp;
  logic [WEIGHT_W-1:0] mul_a;
  logic [31:0]         mul_b;
  logic [48:0]         prod;
  period_t             per_cur;
  speed_t              speed_sat;

  div_req_t div_req;
  div_rsp_t div_rsp;

  tach_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign chan_ok      = (32'(in_ch.channel) < CHANNEL_COUNT);
  assign last_cur     = (cur_r == CH_W'(CHANNEL_COUNT - 1));
  assign per_cur      = per_r[cur_r];

  assign high_sel = ((in_ch.high_first != in_ch.high_second) &&
                     (in_ch.capture_low < HALF_WORD)) ? in_ch.high_second
                                                      : in_ch.high_first;
  assign stamp_in = {high_sel, in_ch.capture_low};

  assign w_clamp = (weight_r > WEIGHT_ONE) ? WEIGHT_ONE : weight_r;
  assign w_comp  = WEIGHT_ONE - w_clamp;

  always_comb begin
    case (step_r)
      2'd0: begin
        mul_a = w_clamp;
        mul_b = diff_r;
      end
      2'd1: begin
        mul_a = w_comp;
        mul_b = per_cur[31:0];
      end
      default: begin
        mul_a = w_comp;
        mul_b = {24'd0, per_cur[PERIOD_W-1:32]};
      end
    endcase
  end

  assign prod = 49'(mul_a) * 49'(mul_b);

  always_comb begin
    case (step_r)
      2'd0:    acc_nxt = (ACC_W'(prod) << 8) + ROUND_HALF;
      2'd1:    acc_nxt = acc_r + ACC_W'(prod);
      default: acc_nxt = acc_r + (ACC_W'(prod) << 32);
    endcase
  end

  assign div_req.start    = (state_r == ST_RD) && (per_cur != '0);
  assign div_req.dividend = {scale_r, 16'd0};
  assign div_req.divisor  = per_cur;

  assign speed_sat = (div_rsp.quot[PERIOD_W-1:SPEED_W] != '0) ? '1
                                                              : div_rsp.quot[SPEED_W-1:0];

  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.mode) begin
            cur_nxt   = '0;
            state_nxt = ST_RD;
          end else if (chan_ok) begin
            cur_nxt   = CH_W'(in_ch.channel);
            state_nxt = ST_DIFF;
          end
        end
      end
      ST_DIFF: begin
        step_nxt  = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD: begin
        if (per_cur != '0) begin
          state_nxt = ST_DIV;
        end else if (last_cur) begin
          state_nxt = ST_FIN;
        end else begin
          cur_nxt = cur_r + 1'b1;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (last_cur) begin
            state_nxt = ST_FIN;
          end else begin
            cur_nxt   = cur_r + 1'b1;
            state_nxt = ST_RD;
          end
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      weight_r    <= WEIGHT_RST;
      scale_r     <= SCALE_RST;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        prev_r[i] <= '0;
        per_r[i]  <= '0;
        last_r[i] <= '1;
      end
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      step_r  <= step_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        case (cfg_ch.addr)
          REG_WEIGHT: weight_r <= cfg_ch.data[WEIGHT_W-1:0];
          REG_SCALE:  scale_r  <= cfg_ch.data[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_DIFF) begin
        prev_r[cur_r] <= stamp_r;
      end
      if ((state_r == ST_MUL) && (step_r == STEP_LAST)) begin
        per_r[cur_r] <= acc_nxt[PERIOD_W+15:16];
      end
      if ((state_r == ST_DIV) && div_rsp.done) begin
        last_r[cur_r] <= speed_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stamp_r <= stamp_in;
    end
    if (state_r == ST_DIFF) begin
      diff_r <= stamp_r - prev_r[cur_r];
    end
    if (state_r == ST_MUL) begin
      acc_r <= acc_nxt;
    end
    if (out_load) begin
      for (int i = 0; i < SPEED_FIELDS; i++) begin
        spd_r[i] <= spd_src[i];
      end
    end
  end

  for (genvar g = 0; g < SPEED_FIELDS; g++) begin : g_spd
    if (g < CHANNEL_COUNT) begin : g_used
      assign spd_src[g] = last_r[g];
    end else begin : g_none
      assign spd_src[g] = '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.speed_zero  = spd_r[0];
  assign out_ch.speed_one   = spd_r[1];
  assign out_ch.speed_two   = spd_r[2];
  assign out_ch.speed_three = spd_r[3];

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("Result became valid outside the result load state.");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_DIV)
    else $error("Divider finished while the sequencer was not waiting on it.");

  a_mul_steps: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL |-> step_r != 2'd3)
    else $error("Multiply sequence ran past its last step.");

endmodule
